>>> rtl/qrdse_pkg.sv
// Shared types, codes and lookup functions for the QR data segment encoder.
package qrdse_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_PAD    = 2'd3
  } cmd_e;

  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_VERSION   = 2'd1;
  localparam logic [1:0] REG_TOTAL     = 2'd2;
  localparam logic [1:0] REG_CODEWORDS = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_CHAR     = 2'd2;
  localparam logic [1:0] ERR_COUNT    = 2'd3;

  // Pending count value that marks a segment whose finish has been sent.
  localparam logic [1:0] FINISHED = 2'd3;

  localparam logic [7:0] PAD_FIRST  = 8'hEC;
  localparam logic [7:0] PAD_SECOND = 8'h11;

  // Bit counter width; the largest capacity is 2956 codewords of 8 bits.
  localparam int CapW = 15;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  bits;
    logic        last;
    logic        done;
    logic [1:0]  err;
  } chunk_t;

  typedef struct packed {
    logic [6:0]  pend_value;
    logic [1:0]  pend_count;
    logic [12:0] chars_seen;
    logic        pad_toggle;
    logic [1:0]  err;
  } enc_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  version;
    logic [12:0] char_total;
    logic [11:0] codewords;
  } cfg_t;

  function automatic logic [4:0] count_width(logic [1:0] mode_eff, logic [5:0] version);
    logic [1:0] cls;
    logic [4:0] w;
    cls = (version >= 6'd27) ? 2'd2 : ((version >= 6'd10) ? 2'd1 : 2'd0);
    case (mode_eff)
      MODE_NUMERIC: w = (cls == 2'd2) ? 5'd14 : ((cls == 2'd1) ? 5'd12 : 5'd10);
      MODE_ALNUM:   w = (cls == 2'd2) ? 5'd13 : ((cls == 2'd1) ? 5'd11 : 5'd9);
      default:      w = (cls == 2'd0) ? 5'd8 : 5'd16;
    endcase
    return w;
  endfunction

  // Returns {valid, code} for the 45-character alphanumeric alphabet.
  function automatic logic [6:0] alnum_code(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h37)};
    end else begin
      case (c)
        8'h20:   r = {1'b1, 6'd36};
        8'h24:   r = {1'b1, 6'd37};
        8'h25:   r = {1'b1, 6'd38};
        8'h2A:   r = {1'b1, 6'd39};
        8'h2B:   r = {1'b1, 6'd40};
        8'h2D:   r = {1'b1, 6'd41};
        8'h2E:   r = {1'b1, 6'd42};
        8'h2F:   r = {1'b1, 6'd43};
        8'h3A:   r = {1'b1, 6'd44};
        default: r = 7'd0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/qr_data_segment_bit_encoder.sv
// QR data segment encoder: streams mode, count, data, terminator and pad bit chunks.
// A command waits in a staging register until the result queue has room for its chunks.
// Throughput: one command per cycle while the queue has room; start and a finish
// with a partial group each give two chunks, and the one-chunk-per-cycle output port
// then sets the pace. The four-entry queue keeps room for two chunks per command.
// Reset clears the queue, the encoder state and loads the register defaults.
module qr_data_segment_bit_encoder #(
  parameter int unsigned MAX_CODEWORDS = 2956
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  char_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] chunk_value_o,
  output logic [4:0]  chunk_bits_o,
  output logic        last_o,
  output logic        done_res_o,
  output logic [1:0]  error_o
);

  qrdse_pkg::cfg_t       cfg_q;
  qrdse_pkg::enc_state_t st_q, st_d;
  logic [qrdse_pkg::CapW-1:0] bits_q, bits_d;

  logic            stg_valid_q;
  qrdse_pkg::cmd_e stg_cmd_q;
  logic [7:0]      stg_char_q;

  logic              fire, room, in_accept, pop, two;
  qrdse_pkg::chunk_t first, second, head;

  assign cfg_ready_o = 1'b1;
  assign fire        = stg_valid_q & room;
  assign in_stall_o  = stg_valid_q & ~fire;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign pop         = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= qrdse_pkg::MODE_NUMERIC;
      cfg_q.version    <= 6'd1;
      cfg_q.char_total <= '0;
      cfg_q.codewords  <= 12'd19;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qrdse_pkg::REG_MODE:      cfg_q.mode       <= cfg_data_i[1:0];
        qrdse_pkg::REG_VERSION:   cfg_q.version    <= cfg_data_i[5:0];
        qrdse_pkg::REG_TOTAL:     cfg_q.char_total <= cfg_data_i;
        qrdse_pkg::REG_CODEWORDS: cfg_q.codewords  <= cfg_data_i[11:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      st_q        <= '0;
      bits_q      <= '0;
    end else begin
      if (in_accept) begin
        stg_valid_q <= 1'b1;
      end else if (fire) begin
        stg_valid_q <= 1'b0;
      end
      if (fire) begin
        st_q   <= st_d;
        bits_q <= bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stg_cmd_q  <= qrdse_pkg::cmd_e'(command_i);
      stg_char_q <= char_byte_i;
    end
  end

  qrdse_step #(
    .MaxCodewords(MAX_CODEWORDS)
  ) u_step (
    .cfg_i    (cfg_q),
    .st_i     (st_q),
    .bits_i   (bits_q),
    .cmd_i    (stg_cmd_q),
    .char_i   (stg_char_q),
    .st_o     (st_d),
    .bits_o   (bits_d),
    .first_o  (first),
    .second_o (second),
    .two_o    (two)
  );

  qrdse_rfifo u_rfifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fire),
    .two_i    (two),
    .first_i  (first),
    .second_i (second),
    .pop_i    (pop),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign chunk_value_o = head.value;
  assign chunk_bits_o  = head.bits;
  assign last_o        = head.last;
  assign done_res_o    = head.done;
  assign error_o       = head.err;

`ifndef SYNTHESIS
  // Every processed command leaves at least one chunk waiting at the output.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed command left no result chunk");

  // A latched error holds until a start command is processed.
  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.err != qrdse_pkg::ERR_OK && !(fire && stg_cmd_q == qrdse_pkg::CMD_START))
      |=> st_q.err == $past(st_q.err))
    else $error("latched error changed without a start");

  // A start clears the character counter and the partial group.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stg_cmd_q == qrdse_pkg::CMD_START)
      |=> (st_q.chars_seen == '0 && st_q.pend_count == '0))
    else $error("start did not clear the segment state");
`endif

endmodule

>>> rtl/qrdse_step.sv
// Next-state and result chunk logic for one command of the segment encoder.
module qrdse_step #(
  parameter int unsigned MaxCodewords = 2956
) (
  input  qrdse_pkg::cfg_t             cfg_i,
  input  qrdse_pkg::enc_state_t       st_i,
  input  logic [qrdse_pkg::CapW-1:0]  bits_i,
  input  qrdse_pkg::cmd_e             cmd_i,
  input  logic [7:0]                  char_i,
  output qrdse_pkg::enc_state_t       st_o,
  output logic [qrdse_pkg::CapW-1:0]  bits_o,
  output qrdse_pkg::chunk_t           first_o,
  output qrdse_pkg::chunk_t           second_o,
  output logic                        two_o
);

  localparam int W = qrdse_pkg::CapW;

  logic [11:0]  cw_clamp;
  logic [W-1:0] cap;
  logic [1:0]   mode_eff;

  assign cw_clamp = (cfg_i.codewords > 12'(MaxCodewords)) ? 12'(MaxCodewords)
                                                         : cfg_i.codewords;
  assign cap      = {cw_clamp, 3'b000};
  assign mode_eff = (cfg_i.mode == 2'd3) ? qrdse_pkg::MODE_BYTE : cfg_i.mode;

  always_comb begin
    logic [4:0]   cnt_w;
    logic [W:0]   be_ext;
    logic [W:0]   sum;
    logic [3:0]   digit;
    logic [10:0]  num_val;
    logic [6:0]   an;
    logic [12:0]  an_val;
    logic [4:0]   fl_w;
    logic [W-1:0] be1;
    logic [W-1:0] rem;
    logic [2:0]   term;
    logic [W-1:0] t_sum;
    logic [2:0]   fill;
    logic [3:0]   tf;
    logic [W-1:0] be_fin;
    logic         flush_ok;
    qrdse_pkg::chunk_t tail;

    st_o     = st_i;
    bits_o   = bits_i;
    two_o    = 1'b0;
    first_o  = '0;
    second_o = '0;
    first_o.done = (bits_i == cap);
    first_o.err  = st_i.err;
    tail     = '0;
    flush_ok = 1'b0;

    cnt_w   = qrdse_pkg::count_width(mode_eff, cfg_i.version);
    be_ext  = {1'b0, bits_i};
    sum     = '0;
    digit   = 4'(char_i - 8'h30);
    num_val = 11'(st_i.pend_value) * 11'd10 + 11'(digit);
    an      = qrdse_pkg::alnum_code(char_i);
    an_val  = 13'(st_i.pend_value) * 13'd45 + 13'(an[5:0]);
    fl_w    = (mode_eff == qrdse_pkg::MODE_NUMERIC) ?
              ((st_i.pend_count == 2'd1) ? 5'd4 : 5'd7) : 5'd6;
    be1     = bits_i;
    rem     = '0;
    term    = '0;
    t_sum   = '0;
    fill    = '0;
    tf      = '0;
    be_fin  = '0;

    if (cmd_i == qrdse_pkg::CMD_START) begin
      st_o   = '0;
      bits_o = '0;
      first_o.err = qrdse_pkg::ERR_OK;
      if (cap == '0) begin
        // No room even for the mode indicator.
        st_o.err     = qrdse_pkg::ERR_OVERFLOW;
        first_o.err  = qrdse_pkg::ERR_OVERFLOW;
        first_o.done = 1'b1;
      end else begin
        first_o.value = 16'(4'b0001 << mode_eff);
        first_o.bits  = 5'd4;
        first_o.done  = 1'b0;
        two_o         = 1'b1;
        sum           = (W+1)'(4) + (W+1)'(cnt_w);
        bits_o        = W'(4);
        if ((cfg_i.char_total >> cnt_w) != '0) begin
          st_o.err     = qrdse_pkg::ERR_COUNT;
          second_o.err = qrdse_pkg::ERR_COUNT;
        end else if (sum > (W+1)'(cap)) begin
          st_o.err     = qrdse_pkg::ERR_OVERFLOW;
          second_o.err = qrdse_pkg::ERR_OVERFLOW;
        end else begin
          bits_o         = sum[W-1:0];
          second_o.value = 16'(cfg_i.char_total);
          second_o.bits  = cnt_w;
          second_o.done  = (sum[W-1:0] == cap);
        end
      end
    end else if (st_i.err != qrdse_pkg::ERR_OK) begin
      // Latched error: an empty result until the next start.
    end else if (cmd_i == qrdse_pkg::CMD_DATA) begin
      if (st_i.pend_count == qrdse_pkg::FINISHED) begin
      end else if (st_i.chars_seen >= cfg_i.char_total) begin
        st_o.err    = qrdse_pkg::ERR_COUNT;
        first_o.err = qrdse_pkg::ERR_COUNT;
      end else if (mode_eff == qrdse_pkg::MODE_NUMERIC) begin
        if (char_i < 8'h30 || char_i > 8'h39) begin
          st_o.err    = qrdse_pkg::ERR_CHAR;
          first_o.err = qrdse_pkg::ERR_CHAR;
        end else if (st_i.pend_count == 2'd2) begin
          sum = be_ext + (W+1)'(10);
          if (sum > (W+1)'(cap)) begin
            st_o.err    = qrdse_pkg::ERR_OVERFLOW;
            first_o.err = qrdse_pkg::ERR_OVERFLOW;
          end else begin
            bits_o          = sum[W-1:0];
            first_o.value   = 16'(num_val);
            first_o.bits    = 5'd10;
            first_o.done    = (sum[W-1:0] == cap);
            st_o.pend_value = '0;
            st_o.pend_count = '0;
            st_o.chars_seen = st_i.chars_seen + 13'd1;
          end
        end else begin
          st_o.pend_value = num_val[6:0];
          st_o.pend_count = st_i.pend_count + 2'd1;
          st_o.chars_seen = st_i.chars_seen + 13'd1;
        end
      end else if (mode_eff == qrdse_pkg::MODE_ALNUM) begin
        if (!an[6]) begin
          st_o.err    = qrdse_pkg::ERR_CHAR;
          first_o.err = qrdse_pkg::ERR_CHAR;
        end else if (st_i.pend_count == 2'd1) begin
          sum = be_ext + (W+1)'(11);
          if (sum > (W+1)'(cap)) begin
            st_o.err    = qrdse_pkg::ERR_OVERFLOW;
            first_o.err = qrdse_pkg::ERR_OVERFLOW;
          end else begin
            bits_o          = sum[W-1:0];
            first_o.value   = 16'(an_val);
            first_o.bits    = 5'd11;
            first_o.done    = (sum[W-1:0] == cap);
            st_o.pend_value = '0;
            st_o.pend_count = '0;
            st_o.chars_seen = st_i.chars_seen + 13'd1;
          end
        end else begin
          st_o.pend_value = {1'b0, an[5:0]};
          st_o.pend_count = 2'd1;
          st_o.chars_seen = st_i.chars_seen + 13'd1;
        end
      end else begin
        sum = be_ext + (W+1)'(8);
        if (sum > (W+1)'(cap)) begin
          st_o.err    = qrdse_pkg::ERR_OVERFLOW;
          first_o.err = qrdse_pkg::ERR_OVERFLOW;
        end else begin
          bits_o          = sum[W-1:0];
          first_o.value   = 16'(char_i);
          first_o.bits    = 5'd8;
          first_o.done    = (sum[W-1:0] == cap);
          st_o.chars_seen = st_i.chars_seen + 13'd1;
        end
      end
    end else if (cmd_i == qrdse_pkg::CMD_FINISH) begin
      if (st_i.pend_count != qrdse_pkg::FINISHED) begin
        flush_ok = 1'b1;
        if (st_i.pend_count != 2'd0) begin
          sum = be_ext + (W+1)'(fl_w);
          if (sum > (W+1)'(cap)) begin
            flush_ok     = 1'b0;
            st_o.err     = qrdse_pkg::ERR_OVERFLOW;
            first_o.err  = qrdse_pkg::ERR_OVERFLOW;
          end else begin
            be1           = sum[W-1:0];
            first_o.value = 16'(st_i.pend_value);
            first_o.bits  = fl_w;
            first_o.done  = (be1 == cap);
            two_o         = 1'b1;
          end
        end
        if (flush_ok) begin
          // Terminator of up to four zeros, then zeros up to a byte boundary,
          // both cut short at the capacity.
          rem   = cap - be1;
          term  = (rem < W'(4)) ? rem[2:0] : 3'd4;
          t_sum = be1 + W'(term);
          fill  = 3'd0 - t_sum[2:0];
          if (W'(term) + W'(fill) > rem) begin
            fill = 3'(rem - W'(term));
          end
          tf              = 4'(term) + 4'(fill);
          be_fin          = be1 + W'(tf);
          bits_o          = be_fin;
          st_o.pend_value = '0;
          st_o.pend_count = qrdse_pkg::FINISHED;
          tail.bits       = 5'(tf);
          tail.done       = (be_fin == cap);
          tail.err        = st_i.err;
          if (two_o) begin
            second_o = tail;
          end else begin
            first_o = tail;
          end
        end
      end
    end else begin
      sum = be_ext + (W+1)'(8);
      if (st_i.pend_count == qrdse_pkg::FINISHED && sum <= (W+1)'(cap)) begin
        bits_o          = sum[W-1:0];
        first_o.value   = 16'(st_i.pad_toggle ? qrdse_pkg::PAD_SECOND : qrdse_pkg::PAD_FIRST);
        first_o.bits    = 5'd8;
        first_o.done    = (sum[W-1:0] == cap);
        st_o.pad_toggle = ~st_i.pad_toggle;
      end
    end

    first_o.last  = ~two_o;
    second_o.last = 1'b1;
  end

endmodule

>>> rtl/qrdse_rfifo.sv
// Result chunk queue: takes one or two chunks per cycle, hands out one per cycle.
module qrdse_rfifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               two_i,
  input  qrdse_pkg::chunk_t  first_i,
  input  qrdse_pkg::chunk_t  second_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic               valid_o,
  output qrdse_pkg::chunk_t  head_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  qrdse_pkg::chunk_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic [PtrW:0]   n_push;

  assign n_push  = push_i ? (two_i ? (PtrW+1)'(2) : (PtrW+1)'(1)) : '0;
  assign wr_d    = wr_q + n_push[PtrW-1:0];
  assign rd_d    = rd_q + PtrW'(pop_i);
  assign cnt_d   = cnt_q + n_push - (PtrW+1)'(pop_i);
  // A push may bring two chunks, so keep space for both.
  assign room_o  = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= first_i;
      if (two_i) begin
        mem_q[wr_q + PtrW'(1)] <= second_i;
      end
    end
  end

endmodule

>>> tb/qr_data_segment_bit_encoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the QR data segment bit encoder with a bit-exact chunk predictor.
module qr_data_segment_bit_encoder_test;

  localparam int MaxCodewords = 2956;
  localparam int TargetItems = 450;
  localparam int QuietLimit = 4000;
  // Character count field width, by mode (numeric, alphanumeric, byte) and version class.
  localparam int CountLen [3][3] = '{'{10, 12, 14}, '{9, 11, 13}, '{8, 16, 16}};
  localparam logic [7:0] AlnumPunct [9] = '{8'h20, 8'h24, 8'h25, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
                                            8'h2F, 8'h3A};

  typedef struct packed {
    qrdse_pkg::cmd_e cmd;
    logic [7:0]      ch;
  } seg_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = qrdse_pkg::REG_MODE;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  qrdse_pkg::cmd_e command_i = qrdse_pkg::CMD_START;
  logic [7:0]  char_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] chunk_value_o;
  logic [4:0]  chunk_bits_o;
  logic        last_o;
  logic        done_res_o;
  logic [1:0]  error_o;

  seg_cmd_t          pending_cmds[$];
  qrdse_pkg::chunk_t expected_chunks[$];

  // Predictor copy of the registers and the segment state.
  logic [1:0]  cfg_mode = qrdse_pkg::MODE_NUMERIC;
  logic [5:0]  cfg_version = 6'd1;
  logic [12:0] cfg_total = '0;
  logic [11:0] cfg_codewords = 12'd19;
  int unsigned seg_bits = 0;
  int unsigned pend_value = 0;
  logic [1:0]  pend_count = '0;
  int unsigned chars_seen = 0;
  logic        pad_phase = 1'b0;
  logic [1:0]  err_latch = qrdse_pkg::ERR_OK;

  int errors = 0;
  int cmds_taken = 0;
  int chunks_seen = 0;
  int error_chunks = 0;
  int full_chunks = 0;
  int settings = 0;
  int items_queued = 0;
  int burst_left = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  logic [7:0] stall_cycle = '0;

  qr_data_segment_bit_encoder #(
    .MAX_CODEWORDS(MaxCodewords)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .char_byte_i  (char_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chunk_value_o(chunk_value_o),
    .chunk_bits_o (chunk_bits_o),
    .last_o       (last_o),
    .done_res_o   (done_res_o),
    .error_o      (error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned capacity_bits();
    return ((cfg_codewords > MaxCodewords) ? MaxCodewords : int'(cfg_codewords)) * 8;
  endfunction

  function automatic void add_chunk(int unsigned value, int unsigned bits);
    qrdse_pkg::chunk_t c;
    c.value = 16'(value);
    c.bits  = 5'(bits);
    c.last  = 1'b0;
    c.done  = (seg_bits == capacity_bits());
    c.err   = err_latch;
    expected_chunks.push_back(c);
  endfunction

  function automatic void latch_error(logic [1:0] code);
    err_latch = code;
    add_chunk(0, 0);
  endfunction

  // A chunk that does not fit the capacity is dropped and flags an overflow.
  function automatic bit append_bits(int unsigned value, int unsigned bits);
    if (seg_bits + bits > capacity_bits()) begin
      latch_error(qrdse_pkg::ERR_OVERFLOW);
      return 1'b0;
    end
    seg_bits += bits;
    add_chunk(value, bits);
    return 1'b1;
  endfunction

  function automatic logic [1:0] effective_mode();
    return (cfg_mode == qrdse_pkg::MODE_NUMERIC || cfg_mode == qrdse_pkg::MODE_ALNUM) ?
           cfg_mode : qrdse_pkg::MODE_BYTE;
  endfunction

  function automatic int alnum_index(logic [7:0] c);
    int k;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 8'h41 + 10;
    for (k = 0; k < 9; k++) begin
      if (c == AlnumPunct[k]) return 36 + k;
    end
    return -1;
  endfunction

  function automatic void start_segment();
    logic [1:0] m;
    int cls;
    int w;
    m = effective_mode();
    seg_bits = 0;
    pend_value = 0;
    pend_count = '0;
    chars_seen = 0;
    pad_phase = 1'b0;
    err_latch = qrdse_pkg::ERR_OK;
    if (!append_bits(1 << m, 4)) return;
    cls = (cfg_version >= 27) ? 2 : ((cfg_version >= 10) ? 1 : 0);
    w = CountLen[m][cls];
    if ((int'(cfg_total) >> w) != 0) begin
      latch_error(qrdse_pkg::ERR_COUNT);
      return;
    end
    void'(append_bits(cfg_total, w));
  endfunction

  function automatic void take_char(logic [7:0] c);
    int v;
    if (pend_count == qrdse_pkg::FINISHED) begin
      add_chunk(0, 0);
      return;
    end
    if (chars_seen >= cfg_total) begin
      latch_error(qrdse_pkg::ERR_COUNT);
      return;
    end
    case (effective_mode())
      qrdse_pkg::MODE_NUMERIC: begin
        if (c < 8'h30 || c > 8'h39) begin
          latch_error(qrdse_pkg::ERR_CHAR);
          return;
        end
        v = int'(c) - 8'h30;
        if (pend_count == 2'd2) begin
          if (!append_bits(pend_value * 10 + v, 10)) return;
          pend_value = 0;
          pend_count = '0;
        end else begin
          pend_value = (pend_value * 10 + v) & 'h7F;
          pend_count = pend_count + 2'd1;
          add_chunk(0, 0);
        end
      end
      qrdse_pkg::MODE_ALNUM: begin
        v = alnum_index(c);
        if (v < 0) begin
          latch_error(qrdse_pkg::ERR_CHAR);
          return;
        end
        if (pend_count == 2'd1) begin
          if (!append_bits(pend_value * 45 + v, 11)) return;
          pend_value = 0;
          pend_count = '0;
        end else begin
          pend_value = v;
          pend_count = 2'd1;
          add_chunk(0, 0);
        end
      end
      default: begin
        if (!append_bits(c, 8)) return;
      end
    endcase
    chars_seen = (chars_seen + 1) & 'h1FFF;
  endfunction

  function automatic void finish_segment();
    int unsigned rem;
    int unsigned term;
    int unsigned fill;
    int unsigned w;
    if (pend_count == qrdse_pkg::FINISHED) begin
      add_chunk(0, 0);
      return;
    end
    if (pend_count != 2'd0) begin
      w = (effective_mode() == qrdse_pkg::MODE_NUMERIC) ? ((pend_count == 2'd1) ? 4 : 7) : 6;
      if (!append_bits(pend_value, w)) return;
    end
    pend_value = 0;
    pend_count = qrdse_pkg::FINISHED;
    // Terminator of up to four zeros, then zero fill to the next byte, both cut at capacity.
    rem = capacity_bits() - seg_bits;
    term = (rem < 4) ? rem : 4;
    fill = (8 - ((seg_bits + term) & 7)) & 7;
    if (term + fill > rem) fill = rem - term;
    seg_bits += term + fill;
    add_chunk(0, term + fill);
  endfunction

  function automatic void pad_step();
    if (pend_count != qrdse_pkg::FINISHED || seg_bits + 8 > capacity_bits()) begin
      add_chunk(0, 0);
      return;
    end
    seg_bits += 8;
    add_chunk(pad_phase ? qrdse_pkg::PAD_SECOND : qrdse_pkg::PAD_FIRST, 8);
    pad_phase = ~pad_phase;
  endfunction

  function automatic void encode_command(qrdse_pkg::cmd_e cmd, logic [7:0] c);
    qrdse_pkg::chunk_t tail;
    if (cmd == qrdse_pkg::CMD_START) begin
      start_segment();
    end else if (err_latch != qrdse_pkg::ERR_OK) begin
      add_chunk(0, 0);
    end else begin
      case (cmd)
        qrdse_pkg::CMD_DATA:   take_char(c);
        qrdse_pkg::CMD_FINISH: finish_segment();
        default:               pad_step();
      endcase
    end
    tail = expected_chunks.pop_back();
    tail.last = 1'b1;
    expected_chunks.push_back(tail);
  endfunction

  function automatic void push_cmd(qrdse_pkg::cmd_e c, logic [7:0] b);
    pending_cmds.push_back('{cmd: c, ch: b});
    items_queued++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_cmd(qrdse_pkg::CMD_DATA, s[i]);
    end
  endfunction

  function automatic logic [7:0] legal_char(logic [1:0] mode);
    int code;
    case (mode)
      qrdse_pkg::MODE_NUMERIC: return 8'h30 + 8'($urandom_range(0, 9));
      qrdse_pkg::MODE_ALNUM: begin
        code = $urandom_range(0, 44);
        if (code < 10) return 8'h30 + 8'(code);
        if (code < 36) return 8'h41 + 8'(code - 10);
        return AlnumPunct[code - 36];
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // The block is idle once every command went in and every chunk came out.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_chunks.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      qrdse_pkg::REG_MODE:    cfg_mode = value[1:0];
      qrdse_pkg::REG_VERSION: cfg_version = value[5:0];
      qrdse_pkg::REG_TOTAL:   cfg_total = value;
      default:                cfg_codewords = value[11:0];
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [1:0] mode, logic [5:0] version, logic [12:0] total,
                           logic [11:0] codewords);
    wait_idle();
    write_reg(qrdse_pkg::REG_MODE, 13'(mode));
    write_reg(qrdse_pkg::REG_VERSION, 13'(version));
    write_reg(qrdse_pkg::REG_TOTAL, total);
    write_reg(qrdse_pkg::REG_CODEWORDS, 13'(codewords));
    settings++;
  endtask

  task automatic random_phase();
    logic [1:0]  mode;
    logic [5:0]  ver;
    logic [12:0] total;
    logic [11:0] cw;
    int kind;
    int len;
    int npad;
    kind = $urandom_range(0, 9);
    mode = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    ver = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
    case ($urandom_range(0, 9))
      0:       cw = 12'($urandom_range(25, 4095));
      1:       cw = 12'(MaxCodewords);
      default: cw = 12'($urandom_range(1, 24));
    endcase
    len = $urandom_range(0, 24);
    case ($urandom_range(0, 9))
      0:       total = 13'($urandom);
      1:       total = 13'(len + $urandom_range(1, 5));
      2:       total = (len > 0) ? 13'(len - 1) : 13'd0;
      default: total = 13'(len);
    endcase
    configure(mode, ver, total, cw);
    if (kind == 0) begin
      // Noise: arbitrary commands in arbitrary order.
      repeat ($urandom_range(4, 16)) begin
        push_cmd(qrdse_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom));
      end
    end else begin
      push_cmd(qrdse_pkg::CMD_START, 8'($urandom));
      for (int i = 0; i < len; i++) begin
        push_cmd(qrdse_pkg::CMD_DATA,
                 ($urandom_range(0, 24) == 0) ? 8'($urandom) : legal_char(mode));
      end
      // A few segments skip the finish so that pads arrive too early.
      if (kind != 1) push_cmd(qrdse_pkg::CMD_FINISH, 8'($urandom));
      npad = $urandom_range(0, (cw < 38) ? int'(cw) + 2 : 40);
      repeat (npad) push_cmd(qrdse_pkg::CMD_PAD, 8'($urandom));
    end
  endtask

  // Command sender: bursts of transfers separated by random gaps.
  always @(posedge clk_i) begin : drive_commands
    seg_cmd_t next;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        encode_command(command_i, char_byte_i);
        cmds_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next = pending_cmds.pop_front();
          in_valid_i  <= 1'b1;
          command_i   <= next.cmd;
          char_byte_i <= next.ch;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Chunk checker; the stall pattern steps through four characters set by the top bits of stall_cycle.
  always @(posedge clk_i) begin : check_chunks
    qrdse_pkg::chunk_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chunks_seen++;
      if (expected_chunks.size() == 0) begin
        $error("unexpected chunk: value %h bits %0d", chunk_value_o, chunk_bits_o);
        errors++;
      end else begin
        want = expected_chunks.pop_front();
        if (want.err != qrdse_pkg::ERR_OK) error_chunks++;
        if (want.done) full_chunks++;
        if (chunk_value_o !== want.value) begin
          $error("chunk_value expected %h got %h", want.value, chunk_value_o);
          errors++;
        end
        if (chunk_bits_o !== want.bits) begin
          $error("chunk_bits expected %0d got %0d", want.bits, chunk_bits_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last expected %b got %b", want.last, last_o);
          errors++;
        end
        if (done_res_o !== want.done) begin
          $error("done_res expected %b got %b", want.done, done_res_o);
          errors++;
        end
        if (error_o !== want.err) begin
          $error("error expected %0d got %0d", want.err, error_o);
          errors++;
        end
      end
    end
    stall_cycle <= stall_cycle + 8'd1;
    case (stall_cycle[7:6])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_cycle[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Timeout: no transfer for %0d cycles", QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run_stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Numeric: full group, one-digit flush, pads, then data and finish after finish.
    configure(qrdse_pkg::MODE_NUMERIC, 6'd1, 13'd8, 12'd19);
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_text("0129");
    push_cmd(qrdse_pkg::CMD_FINISH, 8'h00);
    push_cmd(qrdse_pkg::CMD_PAD, 8'h00);
    push_cmd(qrdse_pkg::CMD_PAD, 8'h00);
    push_text("1");
    push_cmd(qrdse_pkg::CMD_FINISH, 8'h00);
    // Alphanumeric pair that overflows a two-codeword capacity, then a latched error.
    configure(qrdse_pkg::MODE_ALNUM, 6'd10, 13'd3, 12'd2);
    push_cmd(qrdse_pkg::CMD_START, 8'hFF);
    push_text("AZ");
    push_cmd(qrdse_pkg::CMD_PAD, 8'hFF);
    // Byte mode at the top version, widest count and a capacity above the maximum.
    configure(qrdse_pkg::MODE_BYTE, 6'd40, 13'h1FFF, 12'd3000);
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_cmd(qrdse_pkg::CMD_DATA, 8'h00);
    push_cmd(qrdse_pkg::CMD_DATA, 8'hFF);
    push_cmd(qrdse_pkg::CMD_FINISH, 8'h00);
    push_cmd(qrdse_pkg::CMD_PAD, 8'h00);
    // Mode three at version zero: the count does not fit its eight-bit field.
    configure(2'd3, 6'd0, 13'd300, 12'd1);
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_cmd(qrdse_pkg::CMD_DATA, 8'h78);
    // Version above 40: excess character, invalid digit, early pad, pad when full.
    configure(qrdse_pkg::MODE_NUMERIC, 6'd63, 13'd1, 12'd3);
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_text("56");
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_cmd(qrdse_pkg::CMD_DATA, 8'hFF);
    push_cmd(qrdse_pkg::CMD_START, 8'h00);
    push_cmd(qrdse_pkg::CMD_PAD, 8'h00);
    push_text("5");
    push_cmd(qrdse_pkg::CMD_FINISH, 8'h00);
    push_cmd(qrdse_pkg::CMD_PAD, 8'h00);

    while (items_queued < TargetItems) random_phase();

    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d commands under %0d register settings; %0d chunks compared.",
             cmds_taken, settings, chunks_seen);
    $display("%0d chunks carried an error code and %0d marked a full symbol.",
             error_chunks, full_chunks);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
